>>> rtl/eos_pkg.sv
`default_nettype none

package eos_pkg;

    // Field widths fixed by the interface.
    localparam int CFG_W    = 5;
    localparam int OPID_W   = 4;
    localparam int SLOT_W   = 3;
    localparam int RAND_W   = 4;
    localparam int FIT_W    = 16;
    localparam int BITS_W   = 16;

    localparam logic [CFG_W-1:0] NUM_OPS_RESET = 5'd15;

    // Item operation codes.
    localparam logic OP_SELECT   = 1'b0;
    localparam logic OP_FEEDBACK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EVAL,
        ST_REPLACE,
        ST_COMMIT
    } state_t;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic ready;
        logic load;
        logic eval;
        logic replace;
        logic commit;
    } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/eos_slot_mem.sv
`default_nettype none

module eos_slot_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  rd_valid,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    // A row that was never written reads back as not valid; the caller
    // substitutes the reset record for it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

>>> rtl/eos_scan.sv
`default_nettype none

module eos_scan #(
    parameter int GW = 16
) (
    input  wire logic [GW-1:0] genes,
    input  wire logic [4:0]    op_count,
    input  wire logic [3:0]    start,
    output logic      [4:0]    chosen
);

    logic       hi_found;
    logic       lo_found;
    logic [4:0] hi_idx;
    logic [4:0] lo_idx;

    // The circular scan is split into the enabled bits at or above the
    // start and those below it; the lowest hit of the upper part wins.
    always_comb begin
        hi_found = 1'b0;
        lo_found = 1'b0;
        hi_idx   = '0;
        lo_idx   = '0;
        for (int i = GW - 1; i >= 0; i--) begin
            if (genes[i] && (i < int'(op_count))) begin
                if (i >= int'(start)) begin
                    hi_found = 1'b1;
                    hi_idx   = 5'(i);
                end else begin
                    lo_found = 1'b1;
                    lo_idx   = 5'(i);
                end
            end
        end
        if (hi_found) begin
            chosen = hi_idx;
        end else if (lo_found) begin
            chosen = lo_idx;
        end else begin
            chosen = {1'b0, start};
        end
    end

endmodule

`default_nettype wire

>>> rtl/eos_ctrl.sv
`default_nettype none

module eos_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          is_feedback,
    input  wire logic          out_free,
    output eos_pkg::ctrl_t     ctl
);

    eos_pkg::state_t state_reg;
    eos_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eos_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            eos_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = eos_pkg::ST_LOAD;
                end
            end
            eos_pkg::ST_LOAD: begin
                state_next = eos_pkg::ST_EVAL;
            end
            eos_pkg::ST_EVAL: begin
                state_next = is_feedback ? eos_pkg::ST_REPLACE : eos_pkg::ST_COMMIT;
            end
            eos_pkg::ST_REPLACE: begin
                state_next = eos_pkg::ST_COMMIT;
            end
            eos_pkg::ST_COMMIT: begin
                if (out_free) begin
                    state_next = eos_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = eos_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (state_reg)
            eos_pkg::ST_IDLE:    ctl.ready   = 1'b1;
            eos_pkg::ST_LOAD:    ctl.load    = 1'b1;
            eos_pkg::ST_EVAL:    ctl.eval    = 1'b1;
            eos_pkg::ST_REPLACE: ctl.replace = 1'b1;
            eos_pkg::ST_COMMIT:  ctl.commit  = out_free;
            default:             ctl         = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/evolutionary_operator_scheduler.sv
// Flow: a select beat passes through the load, eval and commit states; a feedback beat
// also passes through the replace state before commit. Items are handled one at a time;
// the next beat is taken the cycle after the result is registered.
// The rate is set by the read-modify-write of one slot's record in the slot memory.
// Reset (aresetn, synchronous, active low) clears the sequencer, the output valid and the
// per-slot valid bits at once; unwritten slots read as the reset record, no clearing pass.
`default_nettype none

module evolutionary_operator_scheduler #(
    parameter int NUM_SLOTS     = 8,
    parameter int NUM_PARENTS   = 5,
    parameter int NUM_CHILDREN  = 4,
    parameter int MAX_OPERATORS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Configuration: number of operators in use.
    input  wire logic                        cfg_wr_en,
    input  wire logic [eos_pkg::CFG_W-1:0]   cfg_wr_data,
    // Input channel.
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_operation,
    input  wire logic [eos_pkg::SLOT_W-1:0]  s_slot,
    input  wire logic [eos_pkg::RAND_W-1:0]  s_random_index,
    input  wire logic [eos_pkg::FIT_W-1:0]   s_fitness,
    // Result channel.
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [eos_pkg::OPID_W-1:0]       m_operator_id,
    output logic [eos_pkg::SLOT_W-1:0]       m_best_slot,
    output logic [eos_pkg::BITS_W-1:0]       m_best_parent_bits
);

    localparam int GW  = MAX_OPERATORS;
    localparam int FW  = eos_pkg::FIT_W;
    localparam int PIW = (NUM_PARENTS  > 1) ? $clog2(NUM_PARENTS)  : 1;
    localparam int CIW = (NUM_CHILDREN > 1) ? $clog2(NUM_CHILDREN) : 1;
    localparam int SW  = (NUM_SLOTS    > 1) ? $clog2(NUM_SLOTS)    : 1;

    // Everything one slot owns is kept as a single memory row.
    typedef struct packed {
        logic [NUM_PARENTS-1:0][GW-1:0]  pg;   // parent gene vectors
        logic [NUM_CHILDREN-1:0][GW-1:0] cg;   // child gene vectors
        logic [NUM_PARENTS-1:0][FW-1:0]  pf;   // parent fitness
        logic [NUM_CHILDREN-1:0][FW-1:0] cf;   // child fitness
        logic [CIW-1:0]                  nc;   // current child
        logic [PIW-1:0]                  cp;   // current parent
        logic [PIW-1:0]                  bpi;  // best parent
        logic [CIW-1:0]                  bci;  // best child of this round
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // Slot numbers wrap around the slot count; a few conditional subtracts
    // on a three-bit value do that.
    function automatic logic [eos_pkg::SLOT_W-1:0] slot_reduce(
        input logic [eos_pkg::SLOT_W-1:0] s
    );
        logic [eos_pkg::SLOT_W-1:0] v;
        v = s;
        for (int k = 0; k < 7; k++) begin
            if (int'(v) >= NUM_SLOTS) begin
                v = v - eos_pkg::SLOT_W'(NUM_SLOTS);
            end
        end
        return v;
    endfunction

    // One bit of a restoring remainder. The partial remainder never exceeds
    // the prefix of the random index taken so far, so four bits suffice.
    function automatic logic [3:0] mod_step(
        input logic [3:0] rem,
        input logic       b,
        input logic [4:0] n
    );
        logic [3:0] t;
        t = {rem[2:0], b};
        if ({1'b0, t} >= n) begin
            t = t - n[3:0];
        end
        return t;
    endfunction

    // ---------------------------------------------------------------
    // Configuration and effective operator count.
    // ---------------------------------------------------------------
    logic [eos_pkg::CFG_W-1:0] num_ops_reg;
    logic [4:0]                op_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ops_reg <= eos_pkg::NUM_OPS_RESET;
        end else if (cfg_wr_en) begin
            num_ops_reg <= cfg_wr_data;
        end
    end

    // A count of zero behaves as one; counts beyond the gene width are capped.
    always_comb begin
        if (num_ops_reg == '0) begin
            op_count = 5'd1;
        end else if (int'(num_ops_reg) > MAX_OPERATORS) begin
            op_count = 5'(MAX_OPERATORS);
        end else begin
            op_count = num_ops_reg;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------
    eos_pkg::ctrl_t ctl;
    logic           accept;
    logic           out_free;
    logic           op_reg;

    assign accept   = s_valid && ctl.ready;
    assign s_ready  = ctl.ready;

    eos_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .is_feedback (op_reg == eos_pkg::OP_FEEDBACK),
        .out_free    (out_free),
        .ctl         (ctl)
    );

    // ---------------------------------------------------------------
    // Beat capture. The slot row is read at the accepting edge, and the
    // first half of the random index reduction is done on the way in.
    // ---------------------------------------------------------------
    logic [eos_pkg::SLOT_W-1:0] slot_red;
    logic [eos_pkg::SLOT_W-1:0] slot_reg;
    logic [eos_pkg::RAND_W-1:0] rand_reg;
    logic [FW-1:0]              fit_reg;
    logic [3:0]                 rem_reg;
    logic [3:0]                 r_reg;

    assign slot_red = slot_reduce(s_slot);

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_operation;
            slot_reg <= slot_red;
            rand_reg <= s_random_index;
            fit_reg  <= s_fitness;
            rem_reg  <= mod_step(mod_step(4'd0, s_random_index[3], op_count),
                                 s_random_index[2], op_count);
        end
        if (ctl.load) begin
            r_reg <= mod_step(mod_step(rem_reg, rand_reg[1], op_count),
                              rand_reg[0], op_count);
        end
    end

    // ---------------------------------------------------------------
    // Slot memory.
    // ---------------------------------------------------------------
    logic [REC_W-1:0] rd_data;
    logic             rd_valid;
    logic             wr_en;
    rec_t             rst_rec;
    rec_t             mem_rec;
    rec_t             commit_rec;

    eos_slot_mem #(
        .WIDTH (REC_W),
        .DEPTH (NUM_SLOTS),
        .AW    (SW)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (SW'(slot_red)),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .wr_en    (wr_en),
        .wr_addr  (SW'(slot_reg)),
        .wr_data  (REC_W'(commit_rec))
    );

    always_comb begin
        rst_rec    = '0;
        rst_rec.pg = '1;
        rst_rec.cg = '1;
    end

    assign mem_rec = rd_valid ? rec_t'(rd_data) : rst_rec;

    // ---------------------------------------------------------------
    // Working copy of the slot row and the per-step updates.
    // ---------------------------------------------------------------
    rec_t             rec_reg;
    rec_t             rec_next;
    rec_t             eval_rec;
    rec_t             repl_rec;
    logic             wrap_reg;
    logic [CIW-1:0]   nc_inc_reg;
    logic [4:0]       chosen;
    logic [4:0]       chosen_reg;
    logic [eos_pkg::SLOT_W-1:0] improved_reg;
    logic             repl_take;

    eos_scan #(
        .GW (GW)
    ) u_scan (
        .genes    (rec_reg.cg[rec_reg.nc]),
        .op_count (op_count),
        .start    (r_reg),
        .chosen   (chosen)
    );

    // Feedback, first step: record the child's score and track the best
    // child. When the best child is the current one the compare sees the
    // freshly written score, so it cannot win against itself.
    logic [FW-1:0] best_child_fit;
    logic          eval_wrap;

    always_comb begin
        eval_rec                 = rec_reg;
        eval_rec.cf[rec_reg.nc]  = fit_reg;
        best_child_fit = (rec_reg.bci == rec_reg.nc) ? fit_reg : rec_reg.cf[rec_reg.bci];
        if (fit_reg > best_child_fit) begin
            eval_rec.bci = rec_reg.nc;
        end
        eval_wrap = (rec_reg.nc == CIW'(NUM_CHILDREN - 1));
    end

    // Feedback, second step: at the end of a round the best child takes the
    // current parent's place if it is strictly fitter.
    always_comb begin
        repl_rec  = rec_reg;
        repl_take = wrap_reg && (rec_reg.cf[rec_reg.bci] > rec_reg.pf[rec_reg.cp]);
        if (repl_take) begin
            repl_rec.pg[rec_reg.cp] = rec_reg.cg[rec_reg.bci];
            repl_rec.pf[rec_reg.cp] = rec_reg.cf[rec_reg.bci];
        end
    end

    always_comb begin
        rec_next = rec_reg;
        if (ctl.load) begin
            rec_next = mem_rec;
        end else if (ctl.eval && (op_reg == eos_pkg::OP_FEEDBACK)) begin
            rec_next = eval_rec;
        end else if (ctl.replace) begin
            rec_next = repl_rec;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
        if (ctl.eval) begin
            chosen_reg <= chosen;
            wrap_reg   <= eval_wrap;
            nc_inc_reg <= eval_wrap ? '0 : rec_reg.nc + CIW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            improved_reg <= '0;
        end else if (ctl.replace && repl_take) begin
            improved_reg <= slot_reg;
        end
    end

    // Feedback, last step: close the round (best parent, next parent,
    // cleared scores) and build the next child from the current parent with
    // one gene inverted. A select beat leaves the row as it was read.
    logic [PIW-1:0] cp_adv;

    always_comb begin
        commit_rec = rec_reg;
        cp_adv     = (rec_reg.cp == PIW'(NUM_PARENTS - 1)) ? '0 : rec_reg.cp + PIW'(1);
        if (op_reg == eos_pkg::OP_FEEDBACK) begin
            if (wrap_reg) begin
                if (rec_reg.pf[rec_reg.cp] > rec_reg.pf[rec_reg.bpi]) begin
                    commit_rec.bpi = rec_reg.cp;
                end
                commit_rec.cp  = cp_adv;
                commit_rec.bci = '0;
                commit_rec.cf  = '0;
            end
            commit_rec.nc = nc_inc_reg;
            for (int i = 0; i < GW; i++) begin
                commit_rec.cg[nc_inc_reg][i] =
                    commit_rec.pg[commit_rec.cp][i] ^ (i == int'(r_reg));
            end
        end
    end

    assign wr_en = ctl.commit && (op_reg == eos_pkg::OP_FEEDBACK);

    // ---------------------------------------------------------------
    // Result register. The best parent's genes are shown masked to the
    // operators in use.
    // ---------------------------------------------------------------
    logic [eos_pkg::BITS_W-1:0] best_bits;
    logic                       m_valid_reg;
    logic [eos_pkg::OPID_W-1:0] opid_reg;
    logic [eos_pkg::SLOT_W-1:0] best_slot_reg;
    logic [eos_pkg::BITS_W-1:0] best_bits_reg;

    always_comb begin
        for (int i = 0; i < eos_pkg::BITS_W; i++) begin
            if (i < GW) begin
                best_bits[i] = commit_rec.pg[commit_rec.bpi][i] && (i < int'(op_count));
            end else begin
                best_bits[i] = 1'b0;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.commit) begin
            opid_reg      <= (op_reg == eos_pkg::OP_FEEDBACK) ?
                             '0 : chosen_reg[eos_pkg::OPID_W-1:0];
            best_slot_reg <= improved_reg;
            best_bits_reg <= best_bits;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_operator_id      = opid_reg;
    assign m_best_slot        = best_slot_reg;
    assign m_best_parent_bits = best_bits_reg;

endmodule

`default_nettype wire

>>> rtl/eos_checker.sv
`default_nettype none

module eos_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_operator_id,
    input wire logic [2:0]  m_best_slot,
    input wire logic [15:0] m_best_parent_bits
);

    // The block works on one beat at a time, so it stops taking beats
    // right after one is accepted.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after an accepted beat");

    // A result needs the slot read and the load and eval steps, so m_valid must not rise early.
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid) ##1 !$rose(m_valid))
        else $error("result appeared too early after an accepted beat");

    a_m_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result valid dropped without a handshake");

    a_m_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            ($stable(m_operator_id) && $stable(m_best_slot) && $stable(m_best_parent_bits)))
        else $error("result payload changed while stalled");

endmodule

bind evolutionary_operator_scheduler eos_checker u_eos_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_operator_id      (m_operator_id),
    .m_best_slot        (m_best_slot),
    .m_best_parent_bits (m_best_parent_bits)
);

`default_nettype wire

>>> tb/tb_evolutionary_operator_scheduler.sv
`default_nettype none

module tb_evolutionary_operator_scheduler;

    // The block is built with its default geometry. The predictor below mirrors it.
    localparam int NUM_SLOTS     = 8;
    localparam int NUM_PARENTS   = 5;
    localparam int NUM_CHILDREN  = 4;
    localparam int MAX_OPERATORS = 16;

    // The longest hold-off of the result side, in cycles. It is long enough that the
    // block ends up with a finished result it cannot hand over and so stops taking beats.
    localparam int LONG_HOLD = 300;

    // A run is at most 1858 beats, each with the block's own working time plus a random
    // sender gap and a random result stall; this limit leaves a wide margin over the
    // slowest correct run.
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic                       operation;
        logic [eos_pkg::SLOT_W-1:0] slot;
        logic [eos_pkg::RAND_W-1:0] random_index;
        logic [eos_pkg::FIT_W-1:0]  fitness;
    } sched_item_t;

    typedef struct packed {
        logic [eos_pkg::OPID_W-1:0] operator_id;
        logic [eos_pkg::SLOT_W-1:0] best_slot;
        logic [eos_pkg::BITS_W-1:0] best_parent_bits;
    } sched_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [eos_pkg::CFG_W-1:0]  cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_operation;
    logic [eos_pkg::SLOT_W-1:0] s_slot;
    logic [eos_pkg::RAND_W-1:0] s_random_index;
    logic [eos_pkg::FIT_W-1:0]  s_fitness;
    logic                       m_valid;
    logic                       m_ready;
    logic [eos_pkg::OPID_W-1:0] m_operator_id;
    logic [eos_pkg::SLOT_W-1:0] m_best_slot;
    logic [eos_pkg::BITS_W-1:0] m_best_parent_bits;

    evolutionary_operator_scheduler #(
        .NUM_SLOTS    (NUM_SLOTS),
        .NUM_PARENTS  (NUM_PARENTS),
        .NUM_CHILDREN (NUM_CHILDREN),
        .MAX_OPERATORS(MAX_OPERATORS)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_slot            (s_slot),
        .s_random_index    (s_random_index),
        .s_fitness         (s_fitness),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_operator_id     (m_operator_id),
        .m_best_slot       (m_best_slot),
        .m_best_parent_bits(m_best_parent_bits)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted state of the evolution strategy, one record per slot. The
    // genes are kept at the full vector width; only the low bits that are in
    // use ever get scanned or reported.
    // ------------------------------------------------------------------------
    logic [eos_pkg::BITS_W-1:0] es_parent_genes [NUM_SLOTS][NUM_PARENTS];
    logic [eos_pkg::BITS_W-1:0] es_child_genes  [NUM_SLOTS][NUM_CHILDREN];
    logic [eos_pkg::FIT_W-1:0]  es_parent_fit   [NUM_SLOTS][NUM_PARENTS];
    logic [eos_pkg::FIT_W-1:0]  es_child_fit    [NUM_SLOTS][NUM_CHILDREN];
    int unsigned                es_next_child   [NUM_SLOTS];
    int unsigned                es_cur_parent   [NUM_SLOTS];
    int unsigned                es_best_parent  [NUM_SLOTS];
    int unsigned                es_best_child   [NUM_SLOTS];
    int unsigned                es_improved_slot;
    logic [eos_pkg::CFG_W-1:0]  es_num_ops;

    // Results that the block still owes, oldest first.
    sched_result_t sched_results_due[$];

    int  mismatch_count = 0;
    int  result_count   = 0;
    bit  idle_on        = 1'b1;
    bit  sink_hold_req  = 1'b0;

    // The register value as the block uses it: zero acts as one operator, and
    // anything above the vector width is clipped to the vector width.
    function automatic int unsigned active_ops();
        if (es_num_ops == 0) begin
            return 1;
        end
        if (es_num_ops > MAX_OPERATORS) begin
            return MAX_OPERATORS;
        end
        return es_num_ops;
    endfunction

    task automatic reset_schedule_state();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            for (int k = 0; k < NUM_PARENTS; k++) begin
                es_parent_genes[s][k] = '1;
                es_parent_fit[s][k]   = '0;
            end
            for (int k = 0; k < NUM_CHILDREN; k++) begin
                es_child_genes[s][k] = '1;
                es_child_fit[s][k]   = '0;
            end
            es_next_child[s]  = 0;
            es_cur_parent[s]  = 0;
            es_best_parent[s] = 0;
            es_best_child[s]  = 0;
        end
        es_improved_slot = 0;
        es_num_ops       = eos_pkg::NUM_OPS_RESET;
    endtask

    // Applies one beat to the predicted state and returns the result it yields.
    function automatic sched_result_t evolve_step(sched_item_t it);
        sched_result_t res;
        int unsigned   n;
        int unsigned   s;
        int unsigned   r;
        int unsigned   nc;
        int unsigned   cp;
        int unsigned   bc;
        int unsigned   pick;
        int unsigned   tries;
        logic [eos_pkg::BITS_W-1:0] genes;
        logic [eos_pkg::BITS_W-1:0] in_use;

        n     = active_ops();
        s     = it.slot;
        r     = it.random_index % n;
        pick  = 0;
        if (it.operation == eos_pkg::OP_SELECT) begin
            // Circular scan of the current child from the random start. With no
            // enabled bit the scan comes all the way round to the start again.
            genes = es_child_genes[s][es_next_child[s]];
            pick  = r;
            tries = 0;
            while (genes[pick] == 1'b0 && tries < n) begin
                tries++;
                pick = (pick + 1) % n;
            end
        end else begin
            nc = es_next_child[s];
            cp = es_cur_parent[s];
            es_child_fit[s][nc] = it.fitness;
            if (it.fitness > es_child_fit[s][es_best_child[s]]) begin
                es_best_child[s] = nc;
            end
            nc++;
            if (nc >= NUM_CHILDREN) begin
                // End of a generation. Only a strictly fitter child displaces the
                // parent, and only a strictly fitter parent becomes the best one.
                bc = es_best_child[s];
                if (es_child_fit[s][bc] > es_parent_fit[s][cp]) begin
                    es_parent_genes[s][cp] = es_child_genes[s][bc];
                    es_parent_fit[s][cp]   = es_child_fit[s][bc];
                    es_improved_slot       = s;
                end
                if (es_parent_fit[s][cp] > es_parent_fit[s][es_best_parent[s]]) begin
                    es_best_parent[s] = cp;
                end
                cp = (cp + 1) % NUM_PARENTS;
                es_cur_parent[s] = cp;
                es_best_child[s] = 0;
                nc = 0;
                for (int k = 0; k < NUM_CHILDREN; k++) begin
                    es_child_fit[s][k] = '0;
                end
            end
            es_next_child[s] = nc;
            es_child_genes[s][nc] = es_parent_genes[s][cp] ^ (eos_pkg::BITS_W'(1) << r);
        end

        in_use = (n >= eos_pkg::BITS_W) ? '1 : eos_pkg::BITS_W'((32'd1 << n) - 1);
        res.operator_id      = eos_pkg::OPID_W'(pick);
        res.best_slot        = eos_pkg::SLOT_W'(es_improved_slot);
        res.best_parent_bits = es_parent_genes[s][es_best_parent[s]] & in_use;
        return res;
    endfunction

    function automatic sched_item_t make_item(logic op, int unsigned slot,
                                              int unsigned idx, int unsigned fit);
        sched_item_t it;
        it.operation    = op;
        it.slot         = eos_pkg::SLOT_W'(slot);
        it.random_index = eos_pkg::RAND_W'(idx);
        it.fitness      = eos_pkg::FIT_W'(fit);
        return it;
    endfunction

    // Fitness values lean toward tiny numbers so that ties between children and
    // parents are frequent, with the two extremes mixed in.
    function automatic int unsigned random_fitness();
        case ($urandom_range(0, 9))
            0: begin
                return 0;
            end
            1: begin
                return 16'hFFFF;
            end
            2, 3, 4: begin
                return $urandom_range(0, 3);
            end
            default: begin
                return $urandom & 16'hFFFF;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, result_count, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Sender. The task is entered just after a rising edge, puts the beat on
    // the bus and keeps it there until the block takes it. The prediction is
    // made at the accepting edge, so beats are predicted in the order in which
    // the block sees them. Valid stays high on return unless a gap lowered it; the next
    // beat or a wait takes care of it, so valid is never assigned twice in one step.
    // ------------------------------------------------------------------------
    task automatic offer_item(input sched_item_t it);
        s_valid        <= 1'b1;
        s_operation    <= it.operation;
        s_slot         <= it.slot;
        s_random_index <= it.random_index;
        s_fitness      <= it.fitness;
        do @(posedge aclk); while (!s_ready);
        sched_results_due.push_back(evolve_step(it));
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Lowers valid and waits until the block has handed over every result it
    // owes. Since each beat yields exactly one result, the block is idle then.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (sched_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_operator_count(input logic [eos_pkg::CFG_W-1:0] value);
        wait_until_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        es_num_ops = value;
    endtask

    // ------------------------------------------------------------------------
    // Receiver. Ready drops in random bursts while idling is on, and once for a
    // long stretch when the back-pressure test asks for it.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Every result beat is compared with the oldest outstanding prediction.
    always @(posedge aclk) begin : result_check
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (sched_results_due.size() == 0) begin
                report_mismatch("unexpected result beat", m_operator_id, 0);
            end else begin
                want = sched_results_due.pop_front();
                if (m_operator_id !== want.operator_id) begin
                    report_mismatch("operator_id", m_operator_id, want.operator_id);
                end
                if (m_best_slot !== want.best_slot) begin
                    report_mismatch("best_slot", m_best_slot, want.best_slot);
                end
                if (m_best_parent_bits !== want.best_parent_bits) begin
                    report_mismatch("best_parent_bits", m_best_parent_bits,
                                    want.best_parent_bits);
                end
            end
        end
    end

    // A hung handshake or a lost result ends the run here.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_evolutionary_operator_scheduler: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Fresh slots hold all-ones children, so a select returns its own start,
    // reduced modulo the 15 operators in use after reset. The fitness field of
    // a select beat must have no effect.
    task automatic test_select_after_reset();
        offer_item(make_item(eos_pkg::OP_SELECT, 0, 0, 0));
        offer_item(make_item(eos_pkg::OP_SELECT, 0, 14, 16'hFFFF));
        offer_item(make_item(eos_pkg::OP_SELECT, 7, 15, 16'hFFFF));
        offer_item(make_item(eos_pkg::OP_SELECT, 3, 7, 16'h5A5A));
    endtask

    // One slot runs through three generations: children that only tie the parent,
    // then a fitter one with a tie among the children, then a weaker one that still
    // beats its parent. Selects in between see the flipped genes of the current child.
    task automatic test_generation_turnover();
        for (int k = 0; k < NUM_CHILDREN; k++) begin
            offer_item(make_item(eos_pkg::OP_FEEDBACK, 3, k, 0));
        end
        offer_item(make_item(eos_pkg::OP_SELECT, 3, 3, 0));
        offer_item(make_item(eos_pkg::OP_FEEDBACK, 3, 5, 16'hFFFF));
        offer_item(make_item(eos_pkg::OP_FEEDBACK, 3, 9, 5));
        offer_item(make_item(eos_pkg::OP_SELECT, 3, 9, 0));
        offer_item(make_item(eos_pkg::OP_FEEDBACK, 3, 2, 16'hFFFF));
        offer_item(make_item(eos_pkg::OP_FEEDBACK, 3, 14, 5));
        for (int k = 0; k < NUM_CHILDREN; k++) begin
            offer_item(make_item(eos_pkg::OP_FEEDBACK, 3, 15, 16'h7FFF));
        end
        offer_item(make_item(eos_pkg::OP_SELECT, 3, 14, 0));
    endtask

    // The operator count at its extremes. With one operator every gene flip
    // clears bit 0, so the next select finds nothing enabled and returns its
    // start. Zero behaves as one, and values above the vector width as 16.
    task automatic test_operator_count_limits();
        set_operator_count(5'd1);
        offer_item(make_item(eos_pkg::OP_FEEDBACK, 5, 3, 9));
        offer_item(make_item(eos_pkg::OP_SELECT, 5, 15, 0));
        set_operator_count(5'd31);
        offer_item(make_item(eos_pkg::OP_SELECT, 0, 15, 0));
        offer_item(make_item(eos_pkg::OP_FEEDBACK, 0, 15, 1));
        offer_item(make_item(eos_pkg::OP_SELECT, 0, 15, 0));
        set_operator_count(5'd0);
        offer_item(make_item(eos_pkg::OP_SELECT, 5, 8, 0));
        set_operator_count(5'd16);
        offer_item(make_item(eos_pkg::OP_SELECT, 5, 15, 0));
    endtask

    // Mostly what a fuzzer would send: a select followed by the feedback for
    // that mutation, with starts and genes below the operator count. The rest
    // is noise with operation, slot and index drawn over their full width.
    task automatic test_random_generations(input int pairs, input int unsigned slot_lo,
                                           input int unsigned slot_hi);
        int unsigned slot;
        int unsigned n;
        for (int p = 0; p < pairs; p++) begin
            n    = active_ops();
            slot = $urandom_range(slot_lo, slot_hi);
            if ($urandom_range(0, 99) < 85) begin
                offer_item(make_item(eos_pkg::OP_SELECT, slot, $urandom_range(0, n - 1),
                                     $urandom));
                offer_item(make_item(eos_pkg::OP_FEEDBACK, slot, $urandom_range(0, n - 1),
                                     random_fitness()));
            end else begin
                offer_item(make_item(1'($urandom), $urandom, $urandom,
                                     random_fitness()));
            end
        end
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so the
    // block has to park a finished result and stall its input side.
    task automatic test_result_backpressure();
        sink_hold_req = 1'b1;
        test_random_generations(16, 6, 6);
    endtask

    initial begin : stimulus
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        s_valid        <= 1'b0;
        s_operation    <= eos_pkg::OP_SELECT;
        s_slot         <= '0;
        s_random_index <= '0;
        s_fitness      <= '0;
        reset_schedule_state();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_select_after_reset();
        test_generation_turnover();
        test_operator_count_limits();

        // Random phases under several operator counts. Narrow slot ranges make
        // generations turn over often enough to evolve the parents.
        test_random_generations(110, 0, 1);
        set_operator_count(5'd1);
        test_random_generations(80, 4, 7);
        set_operator_count(5'd2);
        test_random_generations(100, 2, 3);
        set_operator_count(5'd31);
        test_random_generations(100, 0, 7);
        test_result_backpressure();
        set_operator_count(5'd0);
        test_random_generations(60, 0, 3);
        set_operator_count(eos_pkg::CFG_W'($urandom_range(3, 14)));
        test_random_generations(100, 4, 5);

        // The last part runs without idling on either side.
        set_operator_count(eos_pkg::NUM_OPS_RESET);
        idle_on = 1'b0;
        test_random_generations(350, 0, 7);

        wait_until_idle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_evolutionary_operator_scheduler: PASS");
        end else begin
            $display("tb_evolutionary_operator_scheduler: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/eos_pkg.sv
rtl/eos_slot_mem.sv
rtl/eos_scan.sv
rtl/eos_ctrl.sv
rtl/evolutionary_operator_scheduler.sv
rtl/eos_checker.sv
tb/tb_evolutionary_operator_scheduler.sv
